FILE: sv/tcpq_pkg.sv
package tcpq_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned OCC_W       = 5;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic signed [VALUE_W-1:0] THRESHOLD_RESET = 32'sd60;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_PRIORITY = 2'd1,
        CMD_REMOVE   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // the operation that every cell carries out
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PRIO_INSERT,
        CELL_TAIL_INSERT,
        CELL_SHIFT_OUT,
        CELL_RECOUNT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  ins_value;
        logic                       ins_high;
        logic signed [VALUE_W-1:0]  threshold;
    } cell_ctrl_t;

endpackage

FILE: sv/tcpq_cell.sv
module tcpq_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 5
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tcpq_pkg::cell_ctrl_t                  ctrl,
    input  logic [CNT_W-1:0]                      count,
    input  logic signed [tcpq_pkg::VALUE_W-1:0]   left_data,
    input  logic                                  left_run,
    input  logic signed [tcpq_pkg::VALUE_W-1:0]   right_data,
    input  logic                                  right_run,
    output logic signed [tcpq_pkg::VALUE_W-1:0]   data,
    output logic                                  run
);

    logic signed [tcpq_pkg::VALUE_W-1:0] data_reg;
    logic signed [tcpq_pkg::VALUE_W-1:0] data_next;
    logic                                run_reg;
    logic                                run_next;
    logic                                occupied;
    logic                                own_high;

    assign occupied = count > CNT_W'(INDEX);
    assign own_high = data_reg >= ctrl.threshold;

    always_comb
    begin
        data_next = data_reg;
        run_next  = run_reg;
        unique case (ctrl.op)
            tcpq_pkg::CELL_HOLD:
            begin
            end
            tcpq_pkg::CELL_PRIO_INSERT:
            begin
                // high run stays, the next cell takes the value, later ones shift
                if (!run_reg)
                begin
                    data_next = left_run ? ctrl.ins_value : left_data;
                end
                run_next = left_run;
            end
            tcpq_pkg::CELL_TAIL_INSERT:
            begin
                // cells at or past the tail are free, so they all may load
                if (!occupied)
                begin
                    data_next = ctrl.ins_value;
                end
                run_next = run_reg | (left_run & !occupied & ctrl.ins_high);
            end
            tcpq_pkg::CELL_SHIFT_OUT:
            begin
                data_next = right_data;
                run_next  = right_run;
            end
            tcpq_pkg::CELL_RECOUNT:
            begin
                run_next = left_run & own_high & occupied;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    assign data = data_reg;
    assign run  = run_reg;

endmodule

FILE: sv/two_class_priority_queue.sv
// result: registered, the result beat of an accepted input beat is valid in the next cycle
// throughput: one command per cycle while the result register drains, except
// that a threshold write or the remove of a low-class head starts a recount,
// one cell per cycle along the chain; s_axis_tready is low then
// reset: async active low, clears count, high-run flags, result valid and the
// recount; threshold returns to 60, stored entries are left as they are
module two_class_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config: priority threshold
    input  logic                                cfg_wr_en,
    input  logic [tcpq_pkg::VALUE_W-1:0]        cfg_wr_data,
    // command stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] command, [33:2] item_value, [39:34] zero
    input  logic [tcpq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] removed_value, [32] removed_valid, [34:33] status, [39:35] occupancy
    output logic [tcpq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic signed [tcpq_pkg::VALUE_W-1:0] threshold_reg;
    logic [CNT_W-1:0]                    recount_reg;
    logic [CNT_W-1:0]                    recount_next;

    // result register
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [tcpq_pkg::OUT_TDATA_W-1:0]    out_data_reg;
    logic [tcpq_pkg::OUT_TDATA_W-1:0]    out_data_next;

    // ---------------------------------------------------------------
    // input beat decode
    // ---------------------------------------------------------------
    logic                                accept;
    logic                                busy;
    logic [1:0]                          in_command;
    logic signed [tcpq_pkg::VALUE_W-1:0] in_value;
    logic                                in_high;
    logic                                full;
    logic                                empty;
    logic                                recount_start;

    tcpq_pkg::cell_ctrl_t                ctrl;

    // chain wiring: index i of the arrays is what cell i sees on its left, index i+1 is its own output
    logic signed [tcpq_pkg::VALUE_W-1:0] cell_data [QUEUE_DEPTH+1];
    logic                                cell_run  [QUEUE_DEPTH+1];

    logic signed [tcpq_pkg::VALUE_W-1:0] removed_value;
    logic                                removed_valid;
    tcpq_pkg::status_t                   status;

    assign busy          = recount_reg != '0;
    // a pending result may wait while the next beat comes in, as long as it is taken
    assign s_axis_tready = !busy && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_command = s_axis_tdata[1:0];
    assign in_value   = s_axis_tdata[tcpq_pkg::VALUE_W+1:2];
    assign in_high    = in_value >= threshold_reg;
    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty      = count_reg == '0;

    // ---------------------------------------------------------------
    // command decode: one broadcast op to every cell
    // ---------------------------------------------------------------
    always_comb
    begin
        ctrl.op        = tcpq_pkg::CELL_HOLD;
        ctrl.ins_value = in_value;
        ctrl.ins_high  = in_high;
        ctrl.threshold = threshold_reg;
        count_next     = count_reg;
        removed_value  = '0;
        removed_valid  = 1'b0;
        status         = tcpq_pkg::STATUS_OK;
        recount_start  = 1'b0;

        if (busy)
        begin
            // high-run flags settle one cell further each cycle
            ctrl.op = tcpq_pkg::CELL_RECOUNT;
        end
        else if (accept)
        begin
            unique case (in_command)
                tcpq_pkg::CMD_INSERT,
                tcpq_pkg::CMD_PRIORITY:
                begin
                    if (full)
                    begin
                        status = tcpq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        // a low value on a priority insert goes to the tail too
                        if (in_command == tcpq_pkg::CMD_PRIORITY && in_high)
                        begin
                            ctrl.op = tcpq_pkg::CELL_PRIO_INSERT;
                        end
                        else
                        begin
                            ctrl.op = tcpq_pkg::CELL_TAIL_INSERT;
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                tcpq_pkg::CMD_REMOVE:
                begin
                    if (empty)
                    begin
                        status = tcpq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        ctrl.op       = tcpq_pkg::CELL_SHIFT_OUT;
                        removed_value = cell_data[1];
                        removed_valid = 1'b1;
                        count_next    = count_reg - 1'b1;
                        // popping a low-class head can start a new high run, find it again
                        recount_start = !cell_run[1];
                    end
                end
                default:
                begin
                    // unused code: nothing changes, ok result
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // cell chain, head at cell 0
    // ---------------------------------------------------------------
    // left of the head: always "in the run", data never used there
    assign cell_data[0] = '0;
    assign cell_run[0]  = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic signed [tcpq_pkg::VALUE_W-1:0] right_data;
            logic                                right_run;

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                // nothing behind the last cell: it keeps its data, leaves the run
                assign right_data = cell_data[gi+1];
                assign right_run  = 1'b0;
            end
            else
            begin : g_mid
                assign right_data = cell_data[gi+2];
                assign right_run  = cell_run[gi+2];
            end

            tcpq_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .count      (count_reg),
                .left_data  (cell_data[gi]),
                .left_run   (cell_run[gi]),
                .right_data (right_data),
                .right_run  (right_run),
                .data       (cell_data[gi+1]),
                .run        (cell_run[gi+1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // recount timer
    // ---------------------------------------------------------------
    always_comb
    begin
        recount_next = recount_reg;
        if (cfg_wr_en || recount_start)
        begin
            recount_next = CNT_W'(QUEUE_DEPTH);
        end
        else if (busy)
        begin
            recount_next = recount_reg - 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {tcpq_pkg::OCC_W'(count_next), status, removed_valid,
                              removed_value};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            threshold_reg <= tcpq_pkg::THRESHOLD_RESET;
            recount_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            recount_reg   <= recount_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: test/two_class_priority_queue_tb.sv
module two_class_priority_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH       = 16;
    // command code 3 is outside the command list, the block must treat it as a no-op
    localparam logic [1:0]  CMD_NO_OP   = 2'd3;
    // cycles with no beat on either side before the run is declared hung
    localparam int          QUIET_LIMIT = 2000;

    typedef logic signed [tcpq_pkg::VALUE_W-1:0] value_t;

    // one expected result beat
    typedef struct {
        value_t      removed_value;
        logic        removed_valid;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } outcome_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [tcpq_pkg::VALUE_W-1:0]      cfg_wr_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    // [1:0] command, [33:2] item_value, [39:34] zero
    logic [tcpq_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    // [31:0] removed_value, [32] removed_valid, [34:33] status, [39:35] occupancy
    logic [tcpq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

    // shadow copy of the queue contents, head at index 0
    value_t    shadow_entries[$];
    value_t    shadow_threshold;
    // results still owed by the block, oldest first
    outcome_t  pending_outcomes[$];
    int        error_count;
    // when set, neither side inserts gaps or stalls
    bit        no_idle;

    two_class_priority_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // values cluster around the threshold and the extremes of the range
    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0: return shadow_threshold;
            1: return shadow_threshold - 1;
            2: return shadow_threshold + 1;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return '0;
                    default: return -1;
                endcase
            end
            4: return value_t'($urandom_range(0, 120));
            default: return value_t'($urandom);
        endcase
    endfunction

    // predictor: apply one command to the shadow queue and queue up its result
    task automatic apply_command(input logic [1:0] code, input value_t value);
        outcome_t  outcome;
        int        high_run;
        outcome.removed_value = '0;
        outcome.removed_valid = 1'b0;
        outcome.status        = tcpq_pkg::STATUS_OK;
        case (code)
            tcpq_pkg::CMD_INSERT, tcpq_pkg::CMD_PRIORITY:
            begin
                if (shadow_entries.size() >= DEPTH)
                    outcome.status = tcpq_pkg::STATUS_FULL;
                else if (code == tcpq_pkg::CMD_PRIORITY && value >= shadow_threshold)
                begin
                    // lands right behind the leading run of high-class entries
                    high_run = 0;
                    while (high_run < shadow_entries.size() &&
                           shadow_entries[high_run] >= shadow_threshold)
                        high_run++;
                    shadow_entries.insert(high_run, value);
                end
                else
                    shadow_entries.push_back(value);
            end
            tcpq_pkg::CMD_REMOVE:
            begin
                if (shadow_entries.size() == 0)
                    outcome.status = tcpq_pkg::STATUS_EMPTY;
                else
                begin
                    outcome.removed_value = shadow_entries.pop_front();
                    outcome.removed_valid = 1'b1;
                end
            end
            default: ;  // unused code, nothing changes
        endcase
        outcome.occupancy = 5'(shadow_entries.size());
        pending_outcomes.push_back(outcome);
    endtask

    // present one command beat and hold it until accepted
    // here tvalid is only lowered before a gap, so back-to-back beats keep it high
    task automatic send_command(input logic [1:0] code, input value_t value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(tcpq_pkg::IN_TDATA_W - tcpq_pkg::VALUE_W - 2){1'b0}},
                          value, code};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_command(code, value);
    endtask

    task automatic send_random_command(input int insert_pct);
        logic [1:0]  code;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            code = CMD_NO_OP;
        else if (roll < 3 + insert_pct)
            code = ($urandom_range(0, 2) != 0) ? tcpq_pkg::CMD_PRIORITY
                                               : tcpq_pkg::CMD_INSERT;
        else
            code = tcpq_pkg::CMD_REMOVE;
        send_command(code, pick_value());
    endtask

    // stop sending and let every owed result drain out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
    endtask

    // threshold writes only happen once every owed result has drained
    task automatic write_threshold(input value_t value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_threshold = value;
    endtask

    // remove on empty and the unused code on an empty queue, right after reset
    task automatic test_empty_queue();
        send_command(tcpq_pkg::CMD_REMOVE, 32'sh1234_5678);
        send_command(CMD_NO_OP, -1);
    endtask

    // fill with extremes and values on both sides of the reset threshold,
    // then overflow, no-op while full, pop a few from the head and priority-insert again
    task automatic test_fill_and_overflow();
        send_command(tcpq_pkg::CMD_INSERT,   32'sd59);
        send_command(tcpq_pkg::CMD_PRIORITY, 32'sd59);        // just below, goes to tail
        send_command(tcpq_pkg::CMD_PRIORITY, 32'sd60);        // exactly at, jumps ahead
        send_command(tcpq_pkg::CMD_PRIORITY, 32'sh7fff_ffff);
        send_command(tcpq_pkg::CMD_INSERT,   32'sh8000_0000);
        send_command(tcpq_pkg::CMD_PRIORITY, 32'sh8000_0000);
        send_command(tcpq_pkg::CMD_INSERT,   -1);
        send_command(tcpq_pkg::CMD_INSERT,   '0);
        send_command(tcpq_pkg::CMD_PRIORITY, 32'sd61);
        send_command(tcpq_pkg::CMD_INSERT,   32'sh7fff_ffff); // high value via plain insert
        send_command(tcpq_pkg::CMD_PRIORITY, -1);
        send_command(tcpq_pkg::CMD_INSERT,   32'sd60);
        send_command(tcpq_pkg::CMD_PRIORITY, 32'sd1000);
        send_command(tcpq_pkg::CMD_INSERT,   32'sh5555_5555);
        send_command(tcpq_pkg::CMD_PRIORITY, 32'shaaaa_aaaa);
        send_command(tcpq_pkg::CMD_INSERT,   32'sh1234_5678); // sixteenth entry, now full
        send_command(tcpq_pkg::CMD_INSERT,   32'sd7);
        send_command(tcpq_pkg::CMD_PRIORITY, 32'sh7fff_ffff);
        send_command(CMD_NO_OP,              32'sd5);
        repeat (3) send_command(tcpq_pkg::CMD_REMOVE, '0);
        send_command(tcpq_pkg::CMD_PRIORITY, 32'sd60);
    endtask

    // threshold at both ends of the range, around zero, at random and back at
    // reset value, with entries left in the queue across each write
    task automatic test_threshold_sweep();
        value_t settings[6];
        settings = '{32'sh8000_0000, 32'sh7fff_ffff, '0, -1,
                     value_t'($urandom), tcpq_pkg::THRESHOLD_RESET};
        foreach (settings[i])
        begin
            write_threshold(settings[i]);
            for (int n = 0; n < 40; n++)
                send_random_command((n < 20) ? 75 : 35);
        end
    endtask

    // long mixed run, insert bias swings so the queue hits full and empty often
    task automatic test_random_traffic();
        int bias[3];
        bias = '{85, 15, 50};
        for (int n = 0; n < 420; n++)
        begin
            no_idle = (n >= 150 && n < 210);
            send_random_command(bias[(n / 30) % 3]);
        end
        no_idle = 1'b0;
    endtask

    // report one field mismatch
    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endtask

    // result checker, every accepted result beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, tdata %h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (m_axis_tdata[31:0] !== want.removed_value)
                    report_mismatch("removed_value", want.removed_value,
                                    value_t'(m_axis_tdata[31:0]));
                if (m_axis_tdata[32] !== want.removed_valid)
                    report_mismatch("removed_valid", want.removed_valid, m_axis_tdata[32]);
                if (m_axis_tdata[34:33] !== want.status)
                    report_mismatch("status", want.status, m_axis_tdata[34:33]);
                if (m_axis_tdata[39:35] !== want.occupancy)
                    report_mismatch("occupancy", want.occupancy, m_axis_tdata[39:35]);
            end
        end
    end

    // result side backpressure
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // hang detection, counts cycles in which no beat moves on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles", $time, quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        error_count      = 0;
        no_idle          = 1'b0;
        shadow_threshold = tcpq_pkg::THRESHOLD_RESET;
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_and_overflow();
        test_threshold_sweep();
        test_random_traffic();

        // everything sent, wait out the owed results, then give strays time to show
        drain_results();
        repeat (8) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_outcomes.size());
            error_count++;
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
